/* rtl/core/dq_pkg.sv */
`timescale 1ns / 1ps
// dq_pkg: shared types and fixed widths for the DCM to quaternion pipeline.
// No dependencies.
package dq_pkg;

  localparam int MAG_W  = 31;  // normalized magnitude, top bit at position 30
  localparam int NORM_P = 30;
  localparam int SQ_W   = 62;
  localparam int SUM_W  = 64;
  localparam int ROOT_W = 32;
  localparam int ROOT_STAGES = 32;

  localparam logic [1:0] PIV_X = 2'd0;
  localparam logic [1:0] PIV_Y = 2'd1;
  localparam logic [1:0] PIV_Z = 2'd2;
  localparam logic [1:0] PIV_W = 2'd3;

  typedef struct packed {
    logic [3:0] neg;
    logic [1:0] pivot;
    logic       degenerate;
  } dq_side_t;

endpackage

/* rtl/core/dq_front.sv */
`timescale 1ns / 1ps
// dq_front: estimates, pivot choice, vector build and normalization (4 stages).
// Depends on dq_pkg.
module dq_front #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [8:0][DATA_WIDTH-1:0]          m_i,
  output logic                                out_valid,
  output dq_pkg::dq_side_t                    out_side,
  output logic [3:0][dq_pkg::MAG_W-1:0]       out_mag
);
  import dq_pkg::*;

  localparam int BW  = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1;
  localparam int EW  = BW + 3;
  localparam int PW  = $clog2(EW);
  localparam int WW  = EW + MAG_W;
  localparam int SHW = $clog2(WW);

  // stage 1
  logic signed [EW-1:0] x [9];
  logic signed [EW-1:0] g, one;
  logic signed [EW-1:0] est_nxt [4];
  logic signed [EW-1:0] crs_nxt [6];
  logic signed [EW-1:0] est_r [4];
  logic signed [EW-1:0] crs_r [6];
  logic                 v1_r;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      x[k] = EW'($signed(m_i[k]));
    end
    one = EW'(1) <<< FRAC_BITS;
    g   = x[0] + x[4] + x[8];
    est_nxt[0] = one + (x[0] <<< 1) - g;
    est_nxt[1] = one + (x[4] <<< 1) - g;
    est_nxt[2] = one + (x[8] <<< 1) - g;
    est_nxt[3] = one + g;
    crs_nxt[0] = x[1] + x[3];
    crs_nxt[1] = x[6] + x[2];
    crs_nxt[2] = x[5] + x[7];
    crs_nxt[3] = x[5] - x[7];
    crs_nxt[4] = x[6] - x[2];
    crs_nxt[5] = x[1] - x[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    est_r <= est_nxt;
    crs_r <= crs_nxt;
  end

  // stage 2: pivot and vector
  logic [1:0]           piv;
  logic signed [EW-1:0] pest;
  logic signed [EW-1:0] v [4];
  logic [EW-1:0]        mag2_nxt [4];
  dq_side_t             side2_nxt;
  logic [EW-1:0]        mag2_r [4];
  dq_side_t             side2_r;
  logic                 v2_r;

  always_comb begin
    piv  = PIV_X;
    pest = est_r[0];
    if (est_r[1] > pest) begin
      piv  = PIV_Y;
      pest = est_r[1];
    end
    if (est_r[2] > pest) begin
      piv  = PIV_Z;
      pest = est_r[2];
    end
    if (est_r[3] > pest) begin
      piv  = PIV_W;
      pest = est_r[3];
    end
    case (piv)
      PIV_X: begin
        v[0] = est_r[0]; v[1] = crs_r[0]; v[2] = crs_r[1]; v[3] = crs_r[3];
      end
      PIV_Y: begin
        v[0] = crs_r[0]; v[1] = est_r[1]; v[2] = crs_r[2]; v[3] = crs_r[4];
      end
      PIV_Z: begin
        v[0] = crs_r[1]; v[1] = crs_r[2]; v[2] = est_r[2]; v[3] = crs_r[5];
      end
      default: begin
        v[0] = crs_r[3]; v[1] = crs_r[4]; v[2] = crs_r[5]; v[3] = est_r[3];
      end
    endcase
    side2_nxt.pivot      = piv;
    side2_nxt.degenerate = !(pest > 0);
    for (int i = 0; i < 4; i++) begin
      side2_nxt.neg[i] = v[i][EW-1];
      mag2_nxt[i]      = v[i][EW-1] ? EW'(-v[i]) : EW'(v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    mag2_r  <= mag2_nxt;
    side2_r <= side2_nxt;
  end

  // stage 3: leading one of the largest magnitude
  logic [EW-1:0]  orv;
  logic [PW-1:0]  lead;
  logic           shl3_nxt;
  logic [SHW-1:0] amt3_nxt;
  logic [EW-1:0]  mag3_r [4];
  dq_side_t       side3_r;
  logic           shl3_r;
  logic [SHW-1:0] amt3_r;
  logic           v3_r;

  always_comb begin
    orv  = mag2_r[0] | mag2_r[1] | mag2_r[2] | mag2_r[3];
    lead = '0;
    for (int i = 0; i < EW; i++) begin
      if (orv[i]) lead = PW'(i);
    end
    if (int'(lead) > NORM_P) begin
      shl3_nxt = 1'b0;
      amt3_nxt = SHW'(int'(lead) - NORM_P);
    end else begin
      shl3_nxt = 1'b1;
      amt3_nxt = SHW'(NORM_P - int'(lead));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    mag3_r  <= mag2_r;
    side3_r <= side2_r;
    shl3_r  <= shl3_nxt;
    amt3_r  <= amt3_nxt;
  end

  // stage 4: shift
  logic [WW-1:0]              wide [4];
  logic [3:0][MAG_W-1:0]      mag4_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wide[i] = WW'(mag3_r[i]);
      if (shl3_r) begin
        wide[i] = wide[i] << amt3_r;
      end else begin
        wide[i] = wide[i] >> amt3_r;
      end
      mag4_nxt[i] = wide[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3_r;
    end
    out_mag  <= mag4_nxt;
    out_side <= side3_r;
  end

endmodule

/* rtl/core/dq_sumsq.sv */
`timescale 1ns / 1ps
// dq_sumsq: squares of the four magnitudes, then their sum (2 stages).
// Depends on dq_pkg.
module dq_sumsq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  dq_pkg::dq_side_t              in_side,
  input  logic [3:0][dq_pkg::MAG_W-1:0] in_mag,
  output logic                          out_valid,
  output dq_pkg::dq_side_t              out_side,
  output logic [3:0][dq_pkg::MAG_W-1:0] out_mag,
  output logic [dq_pkg::SUM_W-1:0]      out_sum
);
  import dq_pkg::*;

  logic [SQ_W-1:0]        sq_r [4];
  logic [3:0][MAG_W-1:0]  mag_r;
  dq_side_t               side_r;
  logic                   v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_r       <= in_valid;
      out_valid <= v_r;
    end
    for (int i = 0; i < 4; i++) begin
      sq_r[i] <= SQ_W'(in_mag[i]) * SQ_W'(in_mag[i]);
    end
    mag_r    <= in_mag;
    side_r   <= in_side;
    out_sum  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);
    out_mag  <= mag_r;
    out_side <= side_r;
  end

endmodule

/* rtl/core/dq_isqrt.sv */
`timescale 1ns / 1ps
// dq_isqrt: pipelined integer square root, one result bit per stage.
// Depends on dq_pkg.
module dq_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  dq_pkg::dq_side_t              in_side,
  input  logic [3:0][dq_pkg::MAG_W-1:0] in_mag,
  input  logic [dq_pkg::SUM_W-1:0]      in_sum,
  output logic                          out_valid,
  output dq_pkg::dq_side_t              out_side,
  output logic [3:0][dq_pkg::MAG_W-1:0] out_mag,
  output logic [dq_pkg::ROOT_W-1:0]     out_root
);
  import dq_pkg::*;

  logic [SUM_W-1:0]      rem_r  [ROOT_STAGES];
  logic [SUM_W-1:0]      root_r [ROOT_STAGES];
  logic [3:0][MAG_W-1:0] mag_r  [ROOT_STAGES];
  dq_side_t              side_r [ROOT_STAGES];
  logic                  v_r    [ROOT_STAGES];

  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
    localparam logic [SUM_W-1:0] BITV = SUM_W'(1) << (2 * (ROOT_STAGES - 1 - s));
    logic [SUM_W-1:0]      rem_p, root_p, trial;
    logic [3:0][MAG_W-1:0] mag_p;
    dq_side_t              side_p;
    logic                  v_p;

    if (s == 0) begin : g_first
      assign rem_p  = in_sum;
      assign root_p = '0;
      assign mag_p  = in_mag;
      assign side_p = in_side;
      assign v_p    = in_valid;
    end else begin : g_next
      assign rem_p  = rem_r[s-1];
      assign root_p = root_r[s-1];
      assign mag_p  = mag_r[s-1];
      assign side_p = side_r[s-1];
      assign v_p    = v_r[s-1];
    end

    assign trial = root_p + BITV;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_p;
      end
      if (rem_p >= trial) begin
        rem_r[s]  <= rem_p - trial;
        root_r[s] <= (root_p >> 1) + BITV;
      end else begin
        rem_r[s]  <= rem_p;
        root_r[s] <= root_p >> 1;
      end
      mag_r[s]  <= mag_p;
      side_r[s] <= side_p;
    end
  end

  assign out_valid = v_r[ROOT_STAGES-1];
  assign out_side  = side_r[ROOT_STAGES-1];
  assign out_mag   = mag_r[ROOT_STAGES-1];
  assign out_root  = root_r[ROOT_STAGES-1][ROOT_W-1:0];

endmodule

/* rtl/core/dq_div.sv */
`timescale 1ns / 1ps
// dq_div: four-lane pipelined restoring divider, rounded quotient of mag/root.
// Depends on dq_pkg.
module dq_div #(
  parameter int FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  dq_pkg::dq_side_t                  in_side,
  input  logic [3:0][dq_pkg::MAG_W-1:0]     in_mag,
  input  logic [dq_pkg::ROOT_W-1:0]         in_root,
  output logic                              out_valid,
  output dq_pkg::dq_side_t                  out_side,
  output logic [3:0][FRAC_BITS:0]           out_q
);
  import dq_pkg::*;

  localparam int NS = FRAC_BITS + 1;
  localparam int NW = FRAC_BITS + MAG_W + 1;

  // prep stage: numerator with half divisor for rounding
  logic [NW-1:0]               num [4];
  logic [3:0][ROOT_W-1:0]      prem_r;
  logic [3:0][FRAC_BITS:0]     plow_r;
  logic [ROOT_W-1:0]           pn_r;
  dq_side_t                    pside_r;
  logic                        pv_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num[i] = (NW'(in_mag[i]) << FRAC_BITS) + NW'(in_root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= in_valid;
    end
    for (int i = 0; i < 4; i++) begin
      prem_r[i] <= ROOT_W'(num[i][NW-1:FRAC_BITS+1]);
      plow_r[i] <= num[i][FRAC_BITS:0];
    end
    pn_r    <= in_root;
    pside_r <= in_side;
  end

  logic [3:0][ROOT_W-1:0]  rem_r  [NS];
  logic [3:0][FRAC_BITS:0] low_r  [NS];
  logic [3:0][FRAC_BITS:0] q_r    [NS];
  logic [ROOT_W-1:0]       n_r    [NS];
  dq_side_t                side_r [NS];
  logic                    v_r    [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [3:0][ROOT_W-1:0]  rem_p;
    logic [3:0][FRAC_BITS:0] low_p, q_p;
    logic [ROOT_W-1:0]       n_p;
    dq_side_t                side_p;
    logic                    v_p;
    logic [ROOT_W:0]         t [4];

    if (s == 0) begin : g_first
      assign rem_p  = prem_r;
      assign low_p  = plow_r;
      assign q_p    = '0;
      assign n_p    = pn_r;
      assign side_p = pside_r;
      assign v_p    = pv_r;
    end else begin : g_next
      assign rem_p  = rem_r[s-1];
      assign low_p  = low_r[s-1];
      assign q_p    = q_r[s-1];
      assign n_p    = n_r[s-1];
      assign side_p = side_r[s-1];
      assign v_p    = v_r[s-1];
    end

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        t[i] = {rem_p[i], low_p[i][FRAC_BITS]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_p;
      end
      for (int i = 0; i < 4; i++) begin
        if (t[i] >= {1'b0, n_p}) begin
          rem_r[s][i] <= ROOT_W'(t[i] - {1'b0, n_p});
          q_r[s][i]   <= {q_p[i][FRAC_BITS-1:0], 1'b1};
        end else begin
          rem_r[s][i] <= t[i][ROOT_W-1:0];
          q_r[s][i]   <= {q_p[i][FRAC_BITS-1:0], 1'b0};
        end
        low_r[s][i] <= {low_p[i][FRAC_BITS-1:0], 1'b0};
      end
      n_r[s]    <= n_p;
      side_r[s] <= side_p;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_side  = side_r[NS-1];
  assign out_q     = q_r[NS-1];

endmodule

/* rtl/core/dcm_to_quaternion.sv */
`timescale 1ns / 1ps
// Throughput: one matrix per cycle; busy stays low, set by the fully pipelined
// 32-stage square root and dividers.
// Reset: synchronous active-low rst_n clears all valid bits; the receiver cannot stall.
// Top level; depends on dq_pkg, dq_front, dq_sumsq, dq_isqrt, dq_div.
module dcm_to_quaternion #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_m00,
  input  logic signed [DATA_WIDTH-1:0] in_m01,
  input  logic signed [DATA_WIDTH-1:0] in_m02,
  input  logic signed [DATA_WIDTH-1:0] in_m10,
  input  logic signed [DATA_WIDTH-1:0] in_m11,
  input  logic signed [DATA_WIDTH-1:0] in_m12,
  input  logic signed [DATA_WIDTH-1:0] in_m20,
  input  logic signed [DATA_WIDTH-1:0] in_m21,
  input  logic signed [DATA_WIDTH-1:0] in_m22,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_qx,
  output logic signed [DATA_WIDTH-1:0] out_qy,
  output logic signed [DATA_WIDTH-1:0] out_qz,
  output logic signed [DATA_WIDTH-1:0] out_qw,
  output logic [1:0]                   out_pivot,
  output logic                         out_degenerate
);
  import dq_pkg::*;

  localparam int QW = FRAC_BITS + 1;
  localparam int CW = ((QW > DATA_WIDTH) ? QW : DATA_WIDTH) + 1;

  logic [8:0][DATA_WIDTH-1:0] m;
  logic                       f_v, s_v, r_v, d_v;
  dq_side_t                   f_side, s_side, r_side, d_side;
  logic [3:0][MAG_W-1:0]      f_mag, s_mag, r_mag;
  logic [SUM_W-1:0]           s_sum;
  logic [ROOT_W-1:0]          r_root;
  logic [3:0][FRAC_BITS:0]    d_q;

  assign busy = 1'b0;
  assign m = {in_m22, in_m21, in_m20, in_m12, in_m11, in_m10, in_m02, in_m01, in_m00};

  dq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start & ~busy), .m_i(m),
    .out_valid(f_v), .out_side(f_side), .out_mag(f_mag)
  );

  dq_sumsq u_sumsq (
    .clk(clk), .rst_n(rst_n), .in_valid(f_v), .in_side(f_side), .in_mag(f_mag),
    .out_valid(s_v), .out_side(s_side), .out_mag(s_mag), .out_sum(s_sum)
  );

  dq_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .in_valid(s_v), .in_side(s_side), .in_mag(s_mag),
    .in_sum(s_sum), .out_valid(r_v), .out_side(r_side), .out_mag(r_mag), .out_root(r_root)
  );

  dq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .in_valid(r_v), .in_side(r_side), .in_mag(r_mag),
    .in_root(r_root), .out_valid(d_v), .out_side(d_side), .out_q(d_q)
  );

  // saturate and apply sign, or zero the result when degenerate
  logic [CW-1:0]         qe [4];
  logic [CW-1:0]         pos_lim, neg_lim;
  logic [DATA_WIDTH-1:0] res_nxt [4];

  always_comb begin
    pos_lim = (CW'(1) << (DATA_WIDTH - 1)) - CW'(1);
    neg_lim = CW'(1) << (DATA_WIDTH - 1);
    for (int i = 0; i < 4; i++) begin
      qe[i] = CW'(d_q[i]);
      if (d_side.neg[i]) begin
        if (qe[i] > neg_lim) qe[i] = neg_lim;
        res_nxt[i] = DATA_WIDTH'(CW'(0) - qe[i]);
      end else begin
        if (qe[i] > pos_lim) qe[i] = pos_lim;
        res_nxt[i] = DATA_WIDTH'(qe[i]);
      end
      if (d_side.degenerate) res_nxt[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= d_v;
    end
    out_qx         <= res_nxt[0];
    out_qy         <= res_nxt[1];
    out_qz         <= res_nxt[2];
    out_qw         <= res_nxt[3];
    out_pivot      <= d_side.pivot;
    out_degenerate <= d_side.degenerate;
  end

endmodule
